>>> design/rpp_pkg.sv
// Package for the RTP packetizer: shared types, constants and header byte selection.
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int unsigned FRAME_LENGTH_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
  localparam logic [31:0] SSRC_RST         = 32'd0;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1300;

  localparam logic [7:0]  RTP_V2_BYTE = 8'h80;
  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned HDR_IDX_W   = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAYLOAD_TYPE = 2'd0,
    CFG_SSRC         = 2'd1,
    CFG_MAX_PAYLOAD  = 2'd2
  } rpp_cfg_idx_e;

  // One queued word: a payload byte plus its header fields, all but the SSRC.
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        marker;
    logic [6:0]  ptype;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        pkt_last;
    logic        frm_last;
  } rpp_entry_t;

  function automatic logic [7:0] hdr_byte(
    input logic [HDR_IDX_W-1:0] idx,
    input logic                 marker,
    input logic [6:0]           ptype,
    input logic [15:0]          seq,
    input logic [31:0]          ts,
    input logic [31:0]          ssrc
  );
    logic [7:0] b;
    case (idx)
      4'd0:    b = RTP_V2_BYTE;
      4'd1:    b = {marker, ptype};
      4'd2:    b = seq[15:8];
      4'd3:    b = seq[7:0];
      4'd4:    b = ts[31:24];
      4'd5:    b = ts[23:16];
      4'd6:    b = ts[15:8];
      4'd7:    b = ts[7:0];
      4'd8:    b = ssrc[31:24];
      4'd9:    b = ssrc[23:16];
      4'd10:   b = ssrc[15:8];
      4'd11:   b = ssrc[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/rpp_ifs.sv
// Handshake interfaces for the packetizer's input, output and configuration channels.
`timescale 1ns / 1ps

interface rpp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [23:0] frame_bytes;
  logic [31:0] frame_timestamp;
  logic [15:0] first_sequence;

  modport source (output valid, payload_byte, frame_bytes, frame_timestamp, first_sequence,
                  input ready);
  modport sink (input valid, payload_byte, frame_bytes, frame_timestamp, first_sequence,
                output ready);
endinterface

interface rpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_last;
  logic       frame_last;

  modport source (output valid, out_byte, packet_last, frame_last, input ready);
  modport sink (input valid, out_byte, packet_last, frame_last, output ready);
endinterface

interface rpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpp_pkg::CFG_IDX_W-1:0]  index;
  logic [rpp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rtp_payload_packetizer.sv
// An accepted byte goes into the queue, then the output register; the header bytes lead
// it when it opens a chunk. Throughput: one output word per cycle while out_o is ready;
// the input takes one byte per cycle but stalls on a full queue, as while the header goes out.
// Reset: frame, chunk, queue and output state clear; payload type 96, SSRC 0, limit 1300.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module rtp_payload_packetizer #(
  parameter int unsigned FRAME_LENGTH_BITS = rpp_pkg::FRAME_LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH       = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpp_in_if.sink     in_i,
  rpp_out_if.source  out_o,
  rpp_cfg_if.sink    cfg_i
);

  logic [6:0]  ptype_q, ptype_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [15:0] limit_q, limit_d;

  logic                push_valid, push_ready, pop_valid, pop_ready;
  rpp_pkg::rpp_entry_t push_entry, pop_entry;

  always_comb begin
    cfg_i.ready = 1'b1;
    ptype_d     = ptype_q;
    ssrc_d      = ssrc_q;
    limit_d     = limit_q;
    if (cfg_i.valid) begin
      case (rpp_pkg::rpp_cfg_idx_e'(cfg_i.index))
        rpp_pkg::CFG_PAYLOAD_TYPE: ptype_d = cfg_i.data[6:0];
        rpp_pkg::CFG_SSRC:         ssrc_d  = cfg_i.data;
        rpp_pkg::CFG_MAX_PAYLOAD:  limit_d = cfg_i.data[15:0];
        default: ; // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptype_q <= rpp_pkg::PAYLOAD_TYPE_RST;
      ssrc_q  <= rpp_pkg::SSRC_RST;
      limit_q <= rpp_pkg::MAX_PAYLOAD_RST;
    end else begin
      ptype_q <= ptype_d;
      ssrc_q  <= ssrc_d;
      limit_q <= limit_d;
    end
  end

  rpp_front #(
    .FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_s          (in_i),
    .payload_type_i(ptype_q),
    .max_payload_i (limit_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  rpp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_entry_o (pop_entry)
  );

  rpp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_entry_i(pop_entry),
    .ssrc_i     (ssrc_q),
    .out_s      (out_o)
  );

`ifndef SYNTH
  // A frame only ends on a packet boundary.
  a_frame_end_is_packet_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_last |-> out_o.packet_last)
    else $error("frame_last without packet_last");

  // The word after a packet's last byte opens the next header.
  a_header_follows_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.packet_last |=>
      !out_o.valid || (out_o.out_byte == rpp_pkg::RTP_V2_BYTE && !out_o.packet_last))
    else $error("packet not followed by RTP header");

  // Header bytes drain only from a word that opens a chunk.
  a_pop_header_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && !pop_ready && out_o.ready |-> pop_entry.hdr)
    else $error("queue word held back without a header");
`endif

endmodule

>>> design/rpp_front.sv
// Front end: accepts payload bytes, tracks frame and chunk position, builds queue words.
`timescale 1ns / 1ps

module rpp_front #(
  parameter int unsigned FRAME_LENGTH_BITS = rpp_pkg::FRAME_LENGTH_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpp_in_if.sink              in_s,
  input  logic [6:0]          payload_type_i,
  input  logic [15:0]         max_payload_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output rpp_pkg::rpp_entry_t push_entry_o
);

  localparam int unsigned FLB = FRAME_LENGTH_BITS;

  logic [FLB-1:0] offset_q, offset_d;
  logic [FLB-1:0] len_q, len_d;
  logic [15:0]    fill_q, fill_d;
  logic [15:0]    seq_q, seq_d;
  logic [31:0]    ts_q, ts_d;

  logic           start, hdr, marker, frm_end, pkt_end, accept;
  logic [FLB-1:0] flen_raw, flen, remaining, offset_inc;
  logic [15:0]    limit, fill, fill_inc, seq;
  logic [31:0]    ts;

  always_comb begin
    start    = (offset_q == '0);
    flen_raw = FLB'(in_s.frame_bytes);
    // A zero length counts as a one-byte frame.
    if (start) begin
      flen = (flen_raw == '0) ? FLB'(1) : flen_raw;
    end else begin
      flen = len_q;
    end
    ts    = start ? in_s.frame_timestamp : ts_q;
    seq   = start ? in_s.first_sequence : seq_q;
    fill  = start ? 16'd0 : fill_q;
    limit = (max_payload_i == 16'd0) ? 16'd1 : max_payload_i;

    hdr        = (fill == 16'd0);
    remaining  = flen - offset_q;
    marker     = (remaining <= FLB'(limit));
    offset_inc = offset_q + FLB'(1);
    fill_inc   = fill + 16'd1;
    frm_end    = (offset_inc == flen);
    pkt_end    = frm_end || (fill_inc >= limit);

    push_entry_o.data     = in_s.payload_byte;
    push_entry_o.hdr      = hdr;
    push_entry_o.marker   = marker;
    push_entry_o.ptype    = payload_type_i;
    push_entry_o.seq      = seq;
    push_entry_o.ts       = ts;
    push_entry_o.pkt_last = pkt_end;
    push_entry_o.frm_last = frm_end;

    push_valid_o = in_s.valid;
    in_s.ready   = push_ready_i;
    accept       = in_s.valid && push_ready_i;

    offset_d = offset_q;
    len_d    = len_q;
    fill_d   = fill_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    if (accept) begin
      offset_d = frm_end ? '0 : offset_inc;
      len_d    = flen;
      fill_d   = pkt_end ? 16'd0 : fill_inc;
      seq_d    = hdr ? (seq + 16'd1) : seq;
      ts_d     = ts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      len_q    <= '0;
      fill_q   <= 16'd0;
      seq_q    <= 16'd0;
      ts_q     <= 32'd0;
    end else begin
      offset_q <= offset_d;
      len_q    <= len_d;
      fill_q   <= fill_d;
      seq_q    <= seq_d;
      ts_q     <= ts_d;
    end
  end

endmodule

>>> design/rpp_queue.sv
// Short word queue between the front end and the header/payload emitter.
`timescale 1ns / 1ps

module rpp_queue #(
  parameter int unsigned DEPTH = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  rpp_pkg::rpp_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output rpp_pkg::rpp_entry_t pop_entry_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rpp_pkg::rpp_entry_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  always_comb begin
    push_ready_o = (cnt_q != CW'(DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_entry_o  = mem_q[rd_ptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> design/rpp_back.sv
// Back end: expands each queue word into its payload byte, led by the header bytes when it opens a chunk.
`timescale 1ns / 1ps

module rpp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  rpp_pkg::rpp_entry_t pop_entry_i,
  input  logic [31:0]         ssrc_i,
  rpp_out_if.source           out_s
);

  localparam int unsigned IW = rpp_pkg::HDR_IDX_W;

  logic [IW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          pkt_last_q, pkt_last_d;
  logic          frm_last_q, frm_last_d;
  logic          load_ok, hdr_phase, emit;

  always_comb begin
    load_ok     = !out_valid_q || out_s.ready;
    hdr_phase   = pop_entry_i.hdr && (idx_q != IW'(rpp_pkg::HDR_BYTES));
    emit        = pop_valid_i && load_ok;
    // Release the word only once its payload byte goes out.
    pop_ready_o = load_ok && !hdr_phase;

    out_valid_d = out_valid_q && !out_s.ready;
    out_byte_d  = out_byte_q;
    pkt_last_d  = pkt_last_q;
    frm_last_d  = frm_last_q;
    idx_d       = idx_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (hdr_phase) begin
        out_byte_d = rpp_pkg::hdr_byte(idx_q, pop_entry_i.marker, pop_entry_i.ptype,
                                       pop_entry_i.seq, pop_entry_i.ts, ssrc_i);
        pkt_last_d = 1'b0;
        frm_last_d = 1'b0;
        idx_d      = idx_q + IW'(1);
      end else begin
        out_byte_d = pop_entry_i.data;
        pkt_last_d = pop_entry_i.pkt_last;
        frm_last_d = pop_entry_i.frm_last;
        idx_d      = '0;
      end
    end

    out_s.valid       = out_valid_q;
    out_s.out_byte    = out_byte_q;
    out_s.packet_last = pkt_last_q;
    out_s.frame_last  = frm_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    pkt_last_q <= pkt_last_d;
    frm_last_q <= frm_last_d;
  end

endmodule
